### rtl/core/int_to_decimal_ascii_macros.svh
// Assertion macros used by the port-level checker of the decimal ASCII formatter.
`ifndef INT_TO_DECIMAL_ASCII_MACROS_SVH
`define INT_TO_DECIMAL_ASCII_MACROS_SVH

// Clocked assertion, inactive while reset is asserted.
`define ITDA_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds through reset.
`define ITDA_ASSERT_RST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/core/itda_pkg.sv
// Package: request types, character codes and widths of the decimal ASCII formatter.
`timescale 1ns / 1ps

package itda_pkg;

    // field widths
    localparam int VALUE_W  = 32;
    localparam int CHAR_W   = 8;
    localparam int DCOUNT_W = 4;
    localparam int TOTAL_W  = 32;

    // default operand width
    localparam int VALUE_BITS_DEF = 32;

    // character codes
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;

    // input request
    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               signed_mode;
        logic               plus_flag;
        logic               space_flag;
    } t_in_req;

    // output request, one character
    typedef struct packed {
        logic [CHAR_W-1:0]   out_char;
        logic                last;
        logic [DCOUNT_W-1:0] digit_count;
        logic [TOTAL_W-1:0]  total_chars;
    } t_out_req;

    // commands to the BCD converter
    typedef struct packed {
        logic load;
        logic nib_shift;
    } t_dab_cmd;

    // status from the BCD converter
    typedef struct packed {
        logic       done;
        logic [3:0] top_nib;
    } t_dab_stat;

endpackage

### rtl/core/itda_dabble.sv
// Bit-serial binary to BCD converter (shift and add 3) with a nibble shift for output.
`timescale 1ns / 1ps

module itda_dabble #(
    parameter int VALUE_BITS = itda_pkg::VALUE_BITS_DEF,
    parameter int DIGITS     = (VALUE_BITS * 1233) / 4096 + 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  itda_pkg::t_dab_cmd   i_cmd,
    input  logic [VALUE_BITS-1:0] i_mag,
    output itda_pkg::t_dab_stat  o_stat
);
    import itda_pkg::*;

    localparam int BCD_W = 4 * DIGITS;
    localparam int CNT_W = $clog2(VALUE_BITS + 1);

    logic [VALUE_BITS-1:0] r_sr,  n_sr;
    logic [BCD_W-1:0]      r_bcd, n_bcd;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic [BCD_W-1:0]      w_adj;

    // add 3 to every digit of 5 or more, all digits in parallel
    always_comb begin
        for (int k = 0; k < DIGITS; k++) begin
            w_adj[4*k +: 4] = (r_bcd[4*k +: 4] >= 4'd5) ? r_bcd[4*k +: 4] + 4'd3
                                                        : r_bcd[4*k +: 4];
        end
    end

    // next state: load, one conversion bit per cycle, or a nibble shift
    always_comb begin
        n_sr  = r_sr;
        n_bcd = r_bcd;
        n_cnt = r_cnt;
        if (i_cmd.load) begin
            n_sr  = i_mag;
            n_bcd = '0;
            n_cnt = CNT_W'(VALUE_BITS);
        end else if (r_cnt != '0) begin
            n_bcd = {w_adj[BCD_W-2:0], r_sr[VALUE_BITS-1]};
            n_sr  = {r_sr[VALUE_BITS-2:0], 1'b0};
            n_cnt = r_cnt - 1'b1;
        end else if (i_cmd.nib_shift) begin
            n_bcd = {r_bcd[BCD_W-5:0], 4'b0000};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
        r_sr  <= n_sr;
        r_bcd <= n_bcd;
    end

    assign o_stat.done    = (r_cnt == '0);
    assign o_stat.top_nib = r_bcd[BCD_W-1 -: 4];

endmodule

### rtl/core/int_to_decimal_ascii.sv
// Top level of the decimal ASCII formatter: sequencer, prefix and character output.
`timescale 1ns / 1ps

// Takes one integer request and returns its decimal text, one character per output
// request, most significant digit first without leading zeros, last set on the final
// character. Signed mode prefixes '-', '+' or a space. Each request is converted bit
// by bit in the shift-and-add-3 register, its leading zero digits are then skipped,
// and its characters are emitted in order, each held while the output stalls. The
// input stalls from acceptance until the last character is loaded into the output
// register; a waiting character does not block the next request.
module int_to_decimal_ascii #(
    parameter int VALUE_BITS = itda_pkg::VALUE_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  itda_pkg::t_in_req i_in,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output itda_pkg::t_out_req o_out
);
    import itda_pkg::*;

    localparam int DIGITS = (VALUE_BITS * 1233) / 4096 + 1;
    localparam int CNT_W  = $clog2(DIGITS + 1);
    localparam int CP_W   = (VALUE_BITS < VALUE_W) ? VALUE_BITS : VALUE_W;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_CONV = 4'b0010,
        S_SKIP = 4'b0100,
        S_EMIT = 4'b1000
    } t_state;

    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_ndig,  n_ndig;
    logic [CNT_W-1:0]    r_left,  n_left;
    logic                r_pfx_pend, n_pfx_pend;
    logic [CHAR_W-1:0]   r_pfx_char, n_pfx_char;
    logic [TOTAL_W-1:0]  r_total, n_total;
    logic                r_out_valid, n_out_valid;
    t_out_req            r_out, n_out;

    logic                  w_accept;
    logic                  w_take;
    logic                  w_neg;
    logic [VALUE_BITS-1:0] w_opnd;
    logic [VALUE_BITS-1:0] w_mag;
    t_dab_cmd              w_cmd;
    t_dab_stat             w_stat;

    // operand and magnitude
    assign w_accept = i_in_valid && (r_state == S_IDLE);
    assign w_opnd   = VALUE_BITS'(i_in.value[CP_W-1:0]);
    assign w_neg    = i_in.signed_mode && w_opnd[VALUE_BITS-1];
    assign w_mag    = w_neg ? (~w_opnd + VALUE_BITS'(1)) : w_opnd;
    assign w_take   = !r_out_valid || !i_out_stall;

    itda_dabble #(
        .VALUE_BITS (VALUE_BITS),
        .DIGITS     (DIGITS)
    ) u_dabble (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_mag   (w_mag),
        .o_stat  (w_stat)
    );

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_ndig      = r_ndig;
        n_left      = r_left;
        n_pfx_pend  = r_pfx_pend;
        n_pfx_char  = r_pfx_char;
        n_total     = r_total;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        w_cmd       = '0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    w_cmd.load = 1'b1;
                    n_ndig     = CNT_W'(DIGITS);
                    n_pfx_pend = i_in.signed_mode &&
                                 (w_neg || i_in.plus_flag || i_in.space_flag);
                    n_pfx_char = w_neg ? CHAR_MINUS :
                                 (i_in.plus_flag ? CHAR_PLUS : CHAR_SPACE);
                    n_state    = S_CONV;
                end
            end
            S_CONV: begin
                if (w_stat.done) begin
                    n_state = S_SKIP;
                end
            end
            S_SKIP: begin
                // drop leading zero digits, keep at least one
                if ((w_stat.top_nib == 4'd0) && (r_ndig > CNT_W'(1))) begin
                    w_cmd.nib_shift = 1'b1;
                    n_ndig          = r_ndig - 1'b1;
                end else begin
                    n_left  = r_ndig;
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (w_take) begin
                    n_out_valid       = 1'b1;
                    n_total           = r_total + 1'b1;
                    n_out.total_chars = r_total + 1'b1;
                    n_out.digit_count = DCOUNT_W'(r_ndig);
                    if (r_pfx_pend) begin
                        n_out.out_char = r_pfx_char;
                        n_out.last     = 1'b0;
                        n_pfx_pend     = 1'b0;
                    end else begin
                        n_out.out_char  = CHAR_ZERO + {4'b0000, w_stat.top_nib};
                        n_out.last      = (r_left == CNT_W'(1));
                        w_cmd.nib_shift = 1'b1;
                        n_left          = r_left - 1'b1;
                        if (r_left == CNT_W'(1)) begin
                            n_state = S_IDLE;
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ndig      <= '0;
            r_left      <= '0;
            r_pfx_pend  <= 1'b0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ndig      <= n_ndig;
            r_left      <= n_left;
            r_pfx_pend  <= n_pfx_pend;
            r_total     <= n_total;
            r_out_valid <= n_out_valid;
        end
        r_pfx_char <= n_pfx_char;
        r_out      <= n_out;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

### rtl/core/itda_checker.sv
// Port-level checker of the decimal ASCII formatter and its bind to the top level.
`timescale 1ns / 1ps
`include "int_to_decimal_ascii_macros.svh"

module itda_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input itda_pkg::t_in_req  i_in,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input itda_pkg::t_out_req o_out
);
    import itda_pkg::*;

    logic [TOTAL_W-1:0] r_seen;
    logic               w_out_acc;
    logic               w_in_acc;

    assign w_out_acc = o_out_valid && !i_out_stall;
    assign w_in_acc  = i_in_valid && !o_in_stall;

    // count of characters delivered so far
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= '0;
        end else if (w_out_acc) begin
            r_seen <= r_seen + 1'b1;
        end
    end

    `ITDA_ASSERT(a_hold, i_clk, i_rst_n, (o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out)), "stalled output request changed")
    `ITDA_ASSERT_RST(a_rst, i_clk, (!i_rst_n |=> !o_out_valid), "output valid after reset")
    `ITDA_ASSERT(a_busy, i_clk, i_rst_n, (w_in_acc |=> o_in_stall), "input not stalled while converting")
    `ITDA_ASSERT(a_total, i_clk, i_rst_n, (w_out_acc |-> o_out.total_chars == r_seen + 1'b1), "running total skipped or repeated")
    `ITDA_ASSERT(a_lastdig, i_clk, i_rst_n, (o_out_valid && o_out.last |-> (o_out.out_char >= CHAR_ZERO) && (o_out.out_char <= CHAR_NINE)), "last character is not a digit")

endmodule

bind int_to_decimal_ascii itda_checker u_itda_checker (.*);

### verif/int_to_decimal_ascii_checker.sv
// Checker for the decimal ASCII formatter: predicts each number's text and compares it.
`timescale 1ns / 1ps

module int_to_decimal_ascii_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  itda_pkg::t_in_req  i_in,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  itda_pkg::t_out_req i_out,
    output int                 o_fail_count,
    output int                 o_chars_pending
);
    import itda_pkg::*;

    // characters still owed by the block, oldest first
    t_out_req    text_queue[$];
    logic [31:0] char_total;
    int          fail_count;

    assign o_fail_count    = fail_count;
    assign o_chars_pending = text_queue.size();

    // Format one request as decimal text and queue its characters
    function automatic void format_number(input t_in_req r);
        logic [31:0] mag;
        logic        negative;
        logic [3:0]  digs[10];
        logic [7:0]  text[11];
        int          nd;
        int          n;
        t_out_req    c;
        negative = r.signed_mode && r.value[31];
        // the most negative value wraps onto its own magnitude, 2^31
        mag = negative ? (~r.value + 32'd1) : r.value;
        nd = 0;
        do begin
            digs[nd] = 4'(mag % 32'd10);
            mag = mag / 32'd10;
            nd = nd + 1;
        end while (mag != 0);
        n = 0;
        // prefix only in signed mode; minus beats plus beats space
        if (r.signed_mode) begin
            if (negative) begin
                text[n] = CHAR_MINUS;
                n = n + 1;
            end else if (r.plus_flag) begin
                text[n] = CHAR_PLUS;
                n = n + 1;
            end else if (r.space_flag) begin
                text[n] = CHAR_SPACE;
                n = n + 1;
            end
        end
        for (int i = nd - 1; i >= 0; i--) begin
            text[n] = CHAR_ZERO + 8'(digs[i]);
            n = n + 1;
        end
        for (int i = 0; i < n; i++) begin
            char_total    = char_total + 32'd1;
            c.out_char    = text[i];
            c.last        = (i == n - 1);
            c.digit_count = 4'(nd);
            c.total_chars = char_total;
            text_queue.push_back(c);
        end
    endfunction

    // Watch both channels; compare characters, then predict new requests
    always @(posedge i_clk) begin
        t_out_req want;
        if (!i_rst_n) begin
            char_total = '0;
            fail_count = 0;
            text_queue.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (text_queue.size() == 0) begin
                    $error("unexpected character %0h", i_out.out_char);
                    fail_count++;
                end else begin
                    want = text_queue.pop_front();
                    if (i_out.out_char !== want.out_char) begin
                        $error("out_char: expected %0h, got %0h", want.out_char, i_out.out_char);
                        fail_count++;
                    end
                    if (i_out.last !== want.last) begin
                        $error("last: expected %0b, got %0b", want.last, i_out.last);
                        fail_count++;
                    end
                    if (i_out.digit_count !== want.digit_count) begin
                        $error("digit_count: expected %0d, got %0d",
                               want.digit_count, i_out.digit_count);
                        fail_count++;
                    end
                    if (i_out.total_chars !== want.total_chars) begin
                        $error("total_chars: expected %0d, got %0d",
                               want.total_chars, i_out.total_chars);
                        fail_count++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                format_number(i_in);
            end
        end
    end

endmodule

### verif/int_to_decimal_ascii_test.sv
// Testbench top of the decimal ASCII formatter: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module int_to_decimal_ascii_test;
    import itda_pkg::*;

    localparam int PHASE_ITEMS    = 155;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int TAIL_CYCLES    = 80;

    logic     clk = 1'b0;
    logic     rst_n;
    logic     in_valid;
    logic     in_stall;
    t_in_req  in_req;
    logic     out_valid;
    logic     out_stall;
    t_out_req out_req;

    int fail_count;
    int chars_pending;
    int snd_idle_pct;
    int rcv_idle_pct;
    bit hold_req;
    int quiet_cycles;

    always #5 clk = ~clk;

    int_to_decimal_ascii u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in        (in_req),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out       (out_req)
    );

    int_to_decimal_ascii_checker u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .i_in_stall      (in_stall),
        .i_in            (in_req),
        .i_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .i_out           (out_req),
        .o_fail_count    (fail_count),
        .o_chars_pending (chars_pending)
    );

    // Offer one request, idling at random first, and wait until it is taken
    task automatic send_number(input logic [31:0] v, input logic s, input logic p,
                               input logic sp);
        t_in_req r;
        r.value       = v;
        r.signed_mode = s;
        r.plus_flag   = p;
        r.space_flag  = sp;
        while ($urandom_range(99) < snd_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_req   <= r;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    // Values spread over every digit count, decade edges and sign extremes
    function automatic logic [31:0] pick_value();
        longint unsigned p;
        longint unsigned hi;
        logic [31:0]     v;
        p = 1;
        repeat ($urandom_range(9)) p = p * 10;
        hi = (p * 10 - 1 > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : p * 10 - 1;
        case ($urandom_range(5))
            0, 1: v = $urandom;
            2: v = $urandom_range(hi[31:0], p[31:0]);
            3: v = p[31:0] + $urandom_range(2) - 1;
            4: v = -($urandom_range(hi[31:0], p[31:0]));
            default: begin
                case ($urandom_range(4))
                    0: v = 32'h0000_0000;
                    1: v = 32'h8000_0000;
                    2: v = 32'h7FFF_FFFF;
                    3: v = 32'hFFFF_FFFF;
                    default: v = 32'h8000_0001;
                endcase
            end
        endcase
        return v;
    endfunction

    task automatic send_random();
        send_number(pick_value(), ($urandom_range(9) < 6), 1'($urandom_range(1)),
                    1'($urandom_range(1)));
    endtask

    // Receiver: random stalls, plus one long hold-off on request
    initial begin
        bit hold_done;
        hold_done = 1'b0;
        out_stall = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                repeat (HOLD_CYCLES) begin
                    out_stall <= 1'b1;
                    @(posedge clk);
                end
            end
            out_stall <= ($urandom_range(99) < rcv_idle_pct);
        end
    end

    // Watchdog on cycles with no request moving on either side
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // Stimulus and verdict
    initial begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        in_req       = '0;
        hold_req     = 1'b0;
        snd_idle_pct = 37;
        rcv_idle_pct = 50;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero in every mode and prefix choice
        send_number(32'd0, 1'b0, 1'b1, 1'b1);
        send_number(32'd0, 1'b1, 1'b0, 1'b0);
        send_number(32'd0, 1'b1, 1'b1, 1'b0);
        send_number(32'd0, 1'b1, 1'b0, 1'b1);
        send_number(32'd0, 1'b1, 1'b1, 1'b1);
        // full range, unsigned and signed
        send_number(32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0);
        send_number(32'hFFFF_FFFF, 1'b0, 1'b1, 1'b0);
        send_number(32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1);
        // most negative value and its neighbors
        send_number(32'h8000_0000, 1'b1, 1'b0, 1'b0);
        send_number(32'h8000_0000, 1'b0, 1'b0, 1'b1);
        send_number(32'h8000_0001, 1'b1, 1'b1, 1'b0);
        send_number(32'h7FFF_FFFF, 1'b1, 1'b1, 1'b0);
        send_number(32'h7FFF_FFFF, 1'b1, 1'b0, 1'b1);
        // digit count boundaries
        send_number(32'd9, 1'b0, 1'b0, 1'b0);
        send_number(32'd10, 1'b1, 1'b0, 1'b1);
        send_number(32'd99, 1'b1, 1'b0, 1'b0);
        send_number(32'd100, 1'b0, 1'b1, 1'b1);
        send_number(32'd999_999_999, 1'b0, 1'b0, 1'b0);
        send_number(32'd1_000_000_000, 1'b1, 1'b1, 1'b0);
        send_number(-32'sd1_000_000_000, 1'b1, 1'b0, 1'b0);
        send_number(-32'sd9, 1'b1, 1'b0, 1'b1);
        send_number(32'd4_294_967_295, 1'b0, 1'b0, 1'b1);

        repeat (PHASE_ITEMS) send_random();
        snd_idle_pct = 50;
        rcv_idle_pct = 37;
        repeat (PHASE_ITEMS) send_random();
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        // sender keeps offering while the receiver holds off
        hold_req = 1'b1;
        repeat (PHASE_ITEMS) send_random();
        in_valid <= 1'b0;

        while (chars_pending != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
